### rtl/wrsi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wrsi_pkg
// Shared widths, codes and types of the windowed RSI block.
// ============================================================================
package wrsi_pkg;

    // Default ring depth, which is also the largest window that can be latched.
    localparam int MAX_PERIOD_DEFAULT = 64;

    // Field and register widths.
    localparam int PRICE_W  = 32;
    localparam int DIFF_W   = PRICE_W + 1;
    localparam int PERIOD_W = 7;
    localparam int COUNT_W  = PERIOD_W + 1;
    localparam int RSI_W    = 14;
    localparam int STATUS_W = 2;

    // Window length used after reset, before any series start latches one.
    localparam int RESET_PERIOD = 14;

    // Scale of the result: RSI in hundredths of a percent point.
    localparam int RSI_SCALE = 10000;
    localparam int RSI_FLAT  = 5000;
    localparam int RSI_FULL  = 10000;

    // Result status codes, as carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_NORMAL     = 2'd0,
        STATUS_FLAT       = 2'd1,
        STATUS_NO_LOSS    = 2'd2,
        STATUS_NOT_ENOUGH = 2'd3
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RETIRE,
        ST_ACCUM,
        ST_CLASSIFY,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### rtl/wrsi_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// wrsi_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module wrsi_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/wrsi_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// wrsi_divider
// Restoring divider that develops one quotient bit per cycle.
// ============================================================================
module wrsi_divider #(
    parameter int NUM_W = 53,
    parameter int DEN_W = 39
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    output logic [wrsi_pkg::RSI_W-1:0]    quotient,
    output wrsi_pkg::div_stat_t           stat
);

    localparam int Q_W    = wrsi_pkg::RSI_W;
    localparam int STEP_W = $clog2(Q_W);

    logic [NUM_W-1:0]  rem_reg,  rem_next;
    logic [NUM_W-1:0]  den_reg,  den_next;
    logic [Q_W-1:0]    q_reg,    q_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [NUM_W:0]    trial;

    // Trial subtraction; the top bit is the borrow.
    assign trial = {1'b0, rem_reg} - {1'b0, den_reg};

    // One quotient bit per cycle, divisor shifted right each step.
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = NUM_W'(den) << (Q_W - 1);
            q_next    = '0;
            step_next = STEP_W'(Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[NUM_W])
            begin
                rem_next = trial[NUM_W-1:0];
                q_next   = {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[Q_W-2:0], 1'b0};
            end
            den_next = den_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state is reset; the operands are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

### rtl/windowed_rsi.sv
`timescale 1ns / 1ps
// ============================================================================
// windowed_rsi
// Streaming relative strength index over a sliding window of differences.
// ============================================================================
// Usage:
// Each request on the s_axis channel carries one close price in tdata and a
// series start flag in tuser. Every request gives exactly one result on the
// m_axis channel: the RSI in hundredths in tdata and its status in tuser.
// The user writes the window length through cfg_we/cfg_wdata only while
// the block is idle; the block does not enforce this. It takes effect at
// the next series start. One request is in work at a time; the window's
// differences sit in a RAM with a registered read. A first close of a series
// passes FETCH, RETIRE and FINISH; while the window fills ACCUM is added,
// and for a full window ACCUM and CLASSIFY; unless flat or free of losses,
// DIVIDE follows, in which the 14-step restoring divider forms the quotient.
// The next request is accepted in the cycle the result appears.
// When the receiver stalls, the result holds in the output register and the
// block waits before it would overwrite it.
// Reset clears the running sums, the counters and the window length (back
// to 14); the RAM is not cleared, as only entries of the running series are
// ever read.
// ============================================================================
module windowed_rsi #(
    parameter int MAX_PERIOD = wrsi_pkg::MAX_PERIOD_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: window_period.
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    // Input requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] close_price
    input  logic [0:0]  s_axis_tuser,   // [0] series_start
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [13:0] rsi_hundredths, [15:14] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int PERIOD_CAP   = (MAX_PERIOD < 127) ? MAX_PERIOD : 127;
    localparam int PTR_W        = $clog2(MAX_PERIOD);
    localparam int SUM_W        = wrsi_pkg::PRICE_W + $clog2(PERIOD_CAP + 1);
    localparam int PROD_W       = SUM_W + wrsi_pkg::RSI_W;
    localparam int DIFF_W       = wrsi_pkg::DIFF_W;
    localparam int PERIOD_W     = wrsi_pkg::PERIOD_W;
    localparam int COUNT_W      = wrsi_pkg::COUNT_W;
    localparam int RSI_W        = wrsi_pkg::RSI_W;
    localparam int RESET_ACTIVE = (wrsi_pkg::RESET_PERIOD > PERIOD_CAP) ?
                                  PERIOD_CAP : wrsi_pkg::RESET_PERIOD;

    // Magnitude of a signed difference.
    function automatic logic [DIFF_W-1:0] diff_mag(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? (~d + 1'b1) : d;
        return m;
    endfunction

    // A strictly positive difference counts as a gain.
    function automatic logic diff_is_gain(input logic [DIFF_W-1:0] d);
        logic g;
        g = !d[DIFF_W-1] && (d != '0);
        return g;
    endfunction

    wrsi_pkg::state_t    state_reg, state_next;
    wrsi_pkg::div_stat_t div_stat;

    logic [PERIOD_W-1:0] window_reg,  window_next;
    logic [PERIOD_W-1:0] active_reg,  active_next;
    logic [SUM_W-1:0]    gain_reg,    gain_next;
    logic [SUM_W-1:0]    loss_reg,    loss_next;
    logic [31:0]         prev_reg,    prev_next;
    logic [COUNT_W-1:0]  count_reg,   count_next;
    logic [PTR_W-1:0]    ptr_reg,     ptr_next;
    logic [31:0]         close_reg,   close_next;
    logic [DIFF_W-1:0]   diff_reg,    diff_next;
    logic [RSI_W-1:0]    res_rsi_reg, res_rsi_next;
    logic [1:0]          res_st_reg,  res_st_next;
    logic [RSI_W-1:0]    out_rsi_reg, out_rsi_next;
    logic [1:0]          out_st_reg,  out_st_next;
    logic                out_vld_reg, out_vld_next;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                ram_re;
    logic                ram_we;
    logic                div_start;
    logic [DIFF_W-1:0]   ram_rdata;
    logic [DIFF_W-1:0]   diff_now;
    logic [PERIOD_W-1:0] period_latch;
    logic                ptr_wrap;
    logic [PTR_W-1:0]    ptr_adv;
    logic                window_full;
    logic                sums_flat;
    logic                no_loss;
    logic [PROD_W-1:0]   div_num;
    logic [SUM_W-1:0]    div_den;
    logic [RSI_W-1:0]    div_q;

    // Window length latched at a series start, clamped to the ring depth; zero becomes one.
    always_comb
    begin
        if (window_reg == '0)
        begin
            period_latch = PERIOD_W'(1);
        end
        else if (32'(window_reg) > PERIOD_CAP)
        begin
            period_latch = PERIOD_W'(PERIOD_CAP);
        end
        else
        begin
            period_latch = window_reg;
        end
    end

    // Pointer and window bookkeeping.
    always_comb
    begin
        logic [31:0] nxt;
        nxt      = 32'(ptr_reg) + 32'd1;
        ptr_wrap = 32'(ptr_reg) >= 32'(active_reg);
        ptr_adv  = (nxt >= 32'(active_reg)) ? '0 : PTR_W'(nxt);
    end

    assign window_full = 32'(count_reg) >= (32'(active_reg) + 32'd1);
    assign diff_now    = {1'b0, close_reg} - {1'b0, prev_reg};
    assign sums_flat   = (gain_reg == '0) && (loss_reg == '0);
    assign no_loss     = (loss_reg == '0);
    assign in_accept   = s_axis_tvalid && s_axis_tready;
    assign out_free    = !out_vld_reg || m_axis_tready;

    // Divider operands: scaled gain over the sum of both sides.
    assign div_num = PROD_W'(gain_reg) * PROD_W'(wrsi_pkg::RSI_SCALE);
    assign div_den = gain_reg + loss_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = wrsi_pkg::ST_FETCH;
                end
            end
            wrsi_pkg::ST_FETCH:
            begin
                state_next = wrsi_pkg::ST_RETIRE;
            end
            wrsi_pkg::ST_RETIRE:
            begin
                state_next = (count_reg == '0) ? wrsi_pkg::ST_FINISH : wrsi_pkg::ST_ACCUM;
            end
            wrsi_pkg::ST_ACCUM:
            begin
                state_next = window_full ? wrsi_pkg::ST_CLASSIFY : wrsi_pkg::ST_FINISH;
            end
            wrsi_pkg::ST_CLASSIFY:
            begin
                state_next = (sums_flat || no_loss) ? wrsi_pkg::ST_FINISH
                                                    : wrsi_pkg::ST_DIVIDE;
            end
            wrsi_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = wrsi_pkg::ST_FINISH;
                end
            end
            wrsi_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wrsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wrsi_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == wrsi_pkg::ST_IDLE);
        ram_re        = (state_reg == wrsi_pkg::ST_FETCH);
        ram_we        = (state_reg == wrsi_pkg::ST_RETIRE) && (count_reg != '0);
        div_start     = (state_reg == wrsi_pkg::ST_CLASSIFY) && !sums_flat && !no_loss;
        out_load      = (state_reg == wrsi_pkg::ST_FINISH) && out_free;
    end

    // Datapath: sums, counters, pointer and result staging.
    always_comb
    begin
        window_next  = window_reg;
        active_next  = active_reg;
        gain_next    = gain_reg;
        loss_next    = loss_reg;
        prev_next    = prev_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        close_next   = close_reg;
        diff_next    = diff_reg;
        res_rsi_next = res_rsi_reg;
        res_st_next  = res_st_reg;
        out_rsi_next = out_rsi_reg;
        out_st_next  = out_st_reg;
        out_vld_next = out_vld_reg;

        if (cfg_we)
        begin
            window_next = cfg_wdata;
        end

        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    close_next = s_axis_tdata;
                    if (s_axis_tuser[0])
                    begin
                        active_next = period_latch;
                        gain_next   = '0;
                        loss_next   = '0;
                        count_next  = '0;
                        ptr_next    = '0;
                    end
                    else if (ptr_wrap)
                    begin
                        ptr_next = '0;
                    end
                end
            end
            wrsi_pkg::ST_RETIRE:
            begin
                prev_next = close_reg;
                if (count_reg == '0)
                begin
                    // First close of a series: nothing to compare against.
                    count_next   = COUNT_W'(1);
                    res_rsi_next = '0;
                    res_st_next  = wrsi_pkg::STATUS_NOT_ENOUGH;
                end
                else
                begin
                    diff_next = diff_now;
                    if (window_full)
                    begin
                        // Drop the oldest difference of the window.
                        if (diff_is_gain(ram_rdata))
                        begin
                            gain_next = gain_reg - SUM_W'(diff_mag(ram_rdata));
                        end
                        else
                        begin
                            loss_next = loss_reg - SUM_W'(diff_mag(ram_rdata));
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            wrsi_pkg::ST_ACCUM:
            begin
                // Add the newest difference and step the ring.
                if (diff_is_gain(diff_reg))
                begin
                    gain_next = gain_reg + SUM_W'(diff_mag(diff_reg));
                end
                else
                begin
                    loss_next = loss_reg + SUM_W'(diff_mag(diff_reg));
                end
                ptr_next     = ptr_adv;
                res_rsi_next = '0;
                res_st_next  = wrsi_pkg::STATUS_NOT_ENOUGH;
            end
            wrsi_pkg::ST_CLASSIFY:
            begin
                if (sums_flat)
                begin
                    res_rsi_next = RSI_W'(wrsi_pkg::RSI_FLAT);
                    res_st_next  = wrsi_pkg::STATUS_FLAT;
                end
                else if (no_loss)
                begin
                    res_rsi_next = RSI_W'(wrsi_pkg::RSI_FULL);
                    res_st_next  = wrsi_pkg::STATUS_NO_LOSS;
                end
            end
            wrsi_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    res_rsi_next = div_q;
                    res_st_next  = wrsi_pkg::STATUS_NORMAL;
                end
            end
            wrsi_pkg::ST_FETCH,
            wrsi_pkg::ST_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        // Output register.
        if (out_load)
        begin
            out_rsi_next = res_rsi_reg;
            out_st_next  = res_st_reg;
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control and architectural state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wrsi_pkg::ST_IDLE;
            window_reg  <= PERIOD_W'(wrsi_pkg::RESET_PERIOD);
            active_reg  <= PERIOD_W'(RESET_ACTIVE);
            gain_reg    <= '0;
            loss_reg    <= '0;
            prev_reg    <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            active_reg  <= active_next;
            gain_reg    <= gain_next;
            loss_reg    <= loss_next;
            prev_reg    <= prev_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        close_reg   <= close_next;
        diff_reg    <= diff_next;
        res_rsi_reg <= res_rsi_next;
        res_st_reg  <= res_st_next;
        out_rsi_reg <= out_rsi_next;
        out_st_reg  <= out_st_next;
    end

    // Ring of the window's differences.
    wrsi_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (diff_now),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Quotient of scaled gain over total movement.
    wrsi_divider #(
        .NUM_W (PROD_W),
        .DEN_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_rsi_reg};
    assign m_axis_tuser  = out_st_reg;

endmodule

### rtl/wrsi_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wrsi_checker
// Port-level assertions of the windowed RSI block, bound to the top level.
// ============================================================================
module wrsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only one request is in work: input is closed right after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in work");

    // A new result appears only just after the input side has been closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while idle");

    // The RSI value agrees with its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == wrsi_pkg::STATUS_NOT_ENOUGH && m_axis_tdata == 16'd0) ||
            (m_axis_tuser == wrsi_pkg::STATUS_FLAT && m_axis_tdata == 16'd5000) ||
            (m_axis_tuser == wrsi_pkg::STATUS_NO_LOSS && m_axis_tdata == 16'd10000) ||
            (m_axis_tuser == wrsi_pkg::STATUS_NORMAL && m_axis_tdata < 16'd10000))
        else $error("RSI value does not match status");

endmodule

bind windowed_rsi wrsi_checker u_wrsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
